@@ rtl/pumpseq_pkg.sv @@
// Shared types, codes and reset values for the irrigation pump sequencer.
package pumpseq_pkg;

   localparam int unsigned PctWidth  = 7;
   localparam int unsigned TimeWidth = 32;
   localparam int unsigned CsrIndexWidth = 3;

   typedef enum logic [1:0] {
      KIND_UPDATE    = 2'd0,
      KIND_FORCE_ON  = 2'd1,
      KIND_FORCE_OFF = 2'd2,
      KIND_UNUSED    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      MODE_IDLE     = 2'd0,
      MODE_WATERING = 2'd1,
      MODE_COOLDOWN = 2'd2,
      MODE_MANUAL   = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      EV_NONE       = 4'd0,
      EV_START      = 4'd1,
      EV_WET_STOP   = 4'd2,
      EV_SAFETY     = 4'd3,
      EV_ABORT      = 4'd4,
      EV_MANUAL_END = 4'd5,
      EV_COOL_DONE  = 4'd6,
      EV_FORCED_ON  = 4'd7,
      EV_FORCED_OFF = 4'd8
   } event_type;

   // Register indexes on the configuration port
   localparam logic [CsrIndexWidth-1:0] REG_DRY_THRESHOLD = 3'd0;
   localparam logic [CsrIndexWidth-1:0] REG_WET_THRESHOLD = 3'd1;
   localparam logic [CsrIndexWidth-1:0] REG_MIN_ON_TIME   = 3'd2;
   localparam logic [CsrIndexWidth-1:0] REG_MAX_ON_TIME   = 3'd3;
   localparam logic [CsrIndexWidth-1:0] REG_COOLDOWN_TIME = 3'd4;

   localparam logic [PctWidth-1:0]  DRY_THRESHOLD_RESET = 7'd30;
   localparam logic [PctWidth-1:0]  WET_THRESHOLD_RESET = 7'd60;
   localparam logic [TimeWidth-1:0] MIN_ON_TIME_RESET   = 32'd5000;
   localparam logic [TimeWidth-1:0] MAX_ON_TIME_RESET   = 32'd30000;
   localparam logic [TimeWidth-1:0] COOLDOWN_TIME_RESET = 32'd60000;

   typedef struct packed {
      logic [1:0]           kind;
      logic [TimeWidth-1:0] now_ms;
      logic [PctWidth-1:0]  soil_pct;
      logic                 soil_ok;
      logic [TimeWidth-1:0] manual_duration;
   } req_type;

   typedef struct packed {
      logic                 pump_on;
      logic [1:0]           mode;
      logic [3:0]           event_res;
      logic [TimeWidth-1:0] since_change;
   } rsp_type;

   typedef struct packed {
      logic [PctWidth-1:0]  dry_threshold;
      logic [PctWidth-1:0]  wet_threshold;
      logic [TimeWidth-1:0] min_on_time;
      logic [TimeWidth-1:0] max_on_time;
      logic [TimeWidth-1:0] cooldown_time;
   } cfg_type;

endpackage

@@ rtl/pumpseq_csr.sv @@
// Configuration register file of the irrigation pump sequencer.
module pumpseq_csr (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [pumpseq_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [pumpseq_pkg::TimeWidth-1:0]       csr_data,
   output pumpseq_pkg::cfg_type                    cfg
);

   pumpseq_pkg::cfg_type cfg_ff;
   pumpseq_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            pumpseq_pkg::REG_DRY_THRESHOLD:
               cfg_in.dry_threshold = csr_data[pumpseq_pkg::PctWidth-1:0];
            pumpseq_pkg::REG_WET_THRESHOLD:
               cfg_in.wet_threshold = csr_data[pumpseq_pkg::PctWidth-1:0];
            pumpseq_pkg::REG_MIN_ON_TIME:   cfg_in.min_on_time   = csr_data;
            pumpseq_pkg::REG_MAX_ON_TIME:   cfg_in.max_on_time   = csr_data;
            pumpseq_pkg::REG_COOLDOWN_TIME: cfg_in.cooldown_time = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dry_threshold <= pumpseq_pkg::DRY_THRESHOLD_RESET;
         cfg_ff.wet_threshold <= pumpseq_pkg::WET_THRESHOLD_RESET;
         cfg_ff.min_on_time   <= pumpseq_pkg::MIN_ON_TIME_RESET;
         cfg_ff.max_on_time   <= pumpseq_pkg::MAX_ON_TIME_RESET;
         cfg_ff.cooldown_time <= pumpseq_pkg::COOLDOWN_TIME_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/pumpseq_core.sv @@
// Sequencer state and the single-pass step logic for one item.
module pumpseq_core (
   input  logic                 clock,
   input  logic                 reset,
   input  pumpseq_pkg::cfg_type cfg,
   input  pumpseq_pkg::req_type item,
   input  logic                 fire,
   output pumpseq_pkg::rsp_type result
);

   pumpseq_pkg::mode_type               mode_ff, mode_in;
   logic                                relay_ff, relay_in;
   logic [pumpseq_pkg::TimeWidth-1:0]   entry_time_ff, entry_time_in;
   logic [pumpseq_pkg::TimeWidth-1:0]   manual_length_ff, manual_length_in;
   logic [pumpseq_pkg::TimeWidth-1:0]   elapsed;
   pumpseq_pkg::event_type              event_code;
   logic                                entered;

   assign elapsed = item.now_ms - entry_time_ff;

   // Next state
   always_comb begin
      mode_in          = mode_ff;
      relay_in         = relay_ff;
      manual_length_in = manual_length_ff;
      entered          = 1'b0;
      event_code       = pumpseq_pkg::EV_NONE;
      case (pumpseq_pkg::kind_type'(item.kind))
         pumpseq_pkg::KIND_UPDATE: begin
            if (!item.soil_ok && mode_ff == pumpseq_pkg::MODE_WATERING) begin
               event_code = pumpseq_pkg::EV_ABORT;
            end else begin
               case (mode_ff)
                  pumpseq_pkg::MODE_MANUAL: begin
                     if (elapsed >= manual_length_ff) begin
                        event_code = pumpseq_pkg::EV_MANUAL_END;
                     end
                  end
                  pumpseq_pkg::MODE_IDLE: begin
                     if (item.soil_ok && item.soil_pct < cfg.dry_threshold) begin
                        event_code = pumpseq_pkg::EV_START;
                     end
                  end
                  pumpseq_pkg::MODE_WATERING: begin
                     // Safety cutoff takes priority over the wet stop
                     if (elapsed >= cfg.max_on_time) begin
                        event_code = pumpseq_pkg::EV_SAFETY;
                     end else if (item.soil_pct > cfg.wet_threshold &&
                                  elapsed >= cfg.min_on_time) begin
                        event_code = pumpseq_pkg::EV_WET_STOP;
                     end
                  end
                  default: begin
                     if (elapsed >= cfg.cooldown_time) begin
                        event_code = pumpseq_pkg::EV_COOL_DONE;
                     end
                  end
               endcase
            end
         end
         pumpseq_pkg::KIND_FORCE_ON:  event_code = pumpseq_pkg::EV_FORCED_ON;
         pumpseq_pkg::KIND_FORCE_OFF: event_code = pumpseq_pkg::EV_FORCED_OFF;
         default: ;
      endcase

      case (event_code)
         pumpseq_pkg::EV_START: begin
            mode_in  = pumpseq_pkg::MODE_WATERING;
            relay_in = 1'b1;
            entered  = 1'b1;
         end
         pumpseq_pkg::EV_WET_STOP, pumpseq_pkg::EV_SAFETY, pumpseq_pkg::EV_ABORT,
         pumpseq_pkg::EV_MANUAL_END, pumpseq_pkg::EV_FORCED_OFF: begin
            mode_in  = pumpseq_pkg::MODE_COOLDOWN;
            relay_in = 1'b0;
            entered  = 1'b1;
         end
         pumpseq_pkg::EV_FORCED_ON: begin
            mode_in          = pumpseq_pkg::MODE_MANUAL;
            relay_in         = 1'b1;
            manual_length_in = item.manual_duration;
            entered          = 1'b1;
         end
         // Cooldown done keeps entry time
         pumpseq_pkg::EV_COOL_DONE: mode_in = pumpseq_pkg::MODE_IDLE;
         default: ;
      endcase
   end

   assign entry_time_in = entered ? item.now_ms : entry_time_ff;

   // Result
   always_comb begin
      result.pump_on      = relay_in;
      result.mode         = mode_in;
      result.event_res    = event_code;
      result.since_change = entered ? '0 : elapsed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= pumpseq_pkg::MODE_IDLE;
         relay_ff         <= 1'b0;
         entry_time_ff    <= '0;
         manual_length_ff <= '0;
      end else if (fire) begin
         mode_ff          <= mode_in;
         relay_ff         <= relay_in;
         entry_time_ff    <= entry_time_in;
         manual_length_ff <= manual_length_in;
      end
   end

endmodule

@@ rtl/irrigation_pump_sequencer.sv @@
// Top level of the irrigation pump sequencer: input register, step logic, result register.
//
// Four-state pump controller (idle, watering, cooldown, manual). Each transfer on the
// req_ channel is a sensor update, a force-on with a duration, or a force-off, stamped
// with the free-running millisecond time; each one yields exactly one transfer on the
// rsp_ channel carrying relay state, mode, the event it caused and the time since the
// last state entry. An item is captured in an input register, evaluated by one pass of
// compare and subtract logic against the sequencer state and latched into a result
// register, so the block takes one item per cycle while rsp_ is not stalled. A stall
// on rsp_ holds the result register and then the input register; req_stall rises only
// when both are full. Configuration registers are written over the csr_ port (always
// ready) and should be changed only while no item is in flight. Reset clears the
// sequencer to idle with the pump off and loads the default thresholds and times.
module irrigation_pump_sequencer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  pumpseq_pkg::req_type                  req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output pumpseq_pkg::rsp_type                  rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pumpseq_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [pumpseq_pkg::TimeWidth-1:0]     csr_data
);

   pumpseq_pkg::cfg_type cfg;
   pumpseq_pkg::req_type req_ff, req_in;
   pumpseq_pkg::rsp_type rsp_ff, rsp_in;
   pumpseq_pkg::rsp_type step_result;
   logic                 req_valid_ff, req_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 advance;
   logic                 req_take;

   pumpseq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pumpseq_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .item   (req_ff),
      .fire   (advance),
      .result (step_result)
   );

   // Advance the held item when the result register is empty or being drained
   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      req_valid_in = req_take || (req_valid_ff && !advance);
      req_in       = req_take ? req_data : req_ff;
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
      rsp_in       = advance ? step_result : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers hold their value whenever not loaded
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ tb/sv/tb_irrigation_pump_sequencer.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the irrigation pump sequencer: directed table, then random phases.
module tb_irrigation_pump_sequencer;

   // Random items per register setting; eight settings plus the directed table
   // come to roughly two thousand requests.
   localparam int PhaseItems    = 240;
   // Receiver hold-off long enough to fill both pipeline registers and stall req_
   localparam int HoldOffCycles = 60;

   logic                                  clock     = 1'b0;
   logic                                  reset     = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_stall;
   pumpseq_pkg::req_type                  req_data  = '0;
   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b0;
   pumpseq_pkg::rsp_type                  rsp_data;
   logic                                  csr_valid = 1'b0;
   logic                                  csr_ready;
   logic [pumpseq_pkg::CsrIndexWidth-1:0] csr_index = '0;
   logic [pumpseq_pkg::TimeWidth-1:0]     csr_data  = '0;

   irrigation_pump_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Shadow sequencer: settings and state as the block should hold them
   // ------------------------------------------------------------------
   logic [pumpseq_pkg::PctWidth-1:0]  lim_dry    = pumpseq_pkg::DRY_THRESHOLD_RESET;
   logic [pumpseq_pkg::PctWidth-1:0]  lim_wet    = pumpseq_pkg::WET_THRESHOLD_RESET;
   logic [pumpseq_pkg::TimeWidth-1:0] lim_min_on = pumpseq_pkg::MIN_ON_TIME_RESET;
   logic [pumpseq_pkg::TimeWidth-1:0] lim_max_on = pumpseq_pkg::MAX_ON_TIME_RESET;
   logic [pumpseq_pkg::TimeWidth-1:0] lim_cool   = pumpseq_pkg::COOLDOWN_TIME_RESET;

   pumpseq_pkg::mode_type             seq_mode      = pumpseq_pkg::MODE_IDLE;
   logic                              seq_relay     = 1'b0;
   logic [pumpseq_pkg::TimeWidth-1:0] seq_entry_ms  = '0;
   logic [pumpseq_pkg::TimeWidth-1:0] seq_manual_ms = '0;

   // Status words the block still owes us, oldest first
   pumpseq_pkg::rsp_type expected_status[$];

   // Stimulus knobs and bookkeeping
   logic [pumpseq_pkg::TimeWidth-1:0] wall_ms = '0;
   bit  quiet         = 1'b0;
   bit  hold_off_req  = 1'b0;
   int  req_gap_pct   = 10;
   int  rsp_stall_pct = 10;
   int  sent_count    = 0;
   int  checked_count = 0;
   int  settings_count = 1;
   int  fail_count    = 0;
   int  event_seen[16];

   // Advance the shadow sequencer by one request and return the status it reports.
   function automatic pumpseq_pkg::rsp_type status_after(input pumpseq_pkg::req_type r);
      logic [pumpseq_pkg::TimeWidth-1:0] elapsed;
      pumpseq_pkg::event_type            ev;
      pumpseq_pkg::rsp_type              s;
      elapsed = r.now_ms - seq_entry_ms;
      ev = pumpseq_pkg::EV_NONE;
      if (r.kind == pumpseq_pkg::KIND_UPDATE) begin
         // an invalid sample aborts watering ahead of every other test
         if (!r.soil_ok && seq_mode == pumpseq_pkg::MODE_WATERING) begin
            ev = pumpseq_pkg::EV_ABORT;
         end else begin
            case (seq_mode)
               pumpseq_pkg::MODE_MANUAL: begin
                  if (elapsed >= seq_manual_ms) ev = pumpseq_pkg::EV_MANUAL_END;
               end
               pumpseq_pkg::MODE_IDLE: begin
                  if (r.soil_ok && r.soil_pct < lim_dry) ev = pumpseq_pkg::EV_START;
               end
               pumpseq_pkg::MODE_WATERING: begin
                  // safety cutoff wins over the wet stop
                  if (elapsed >= lim_max_on) ev = pumpseq_pkg::EV_SAFETY;
                  else if (r.soil_pct > lim_wet && elapsed >= lim_min_on)
                     ev = pumpseq_pkg::EV_WET_STOP;
               end
               default: begin
                  if (elapsed >= lim_cool) ev = pumpseq_pkg::EV_COOL_DONE;
               end
            endcase
         end
      end else if (r.kind == pumpseq_pkg::KIND_FORCE_ON) begin
         seq_manual_ms = r.manual_duration;
         ev = pumpseq_pkg::EV_FORCED_ON;
      end else if (r.kind == pumpseq_pkg::KIND_FORCE_OFF) begin
         ev = pumpseq_pkg::EV_FORCED_OFF;
      end

      case (ev)
         pumpseq_pkg::EV_NONE: ;
         pumpseq_pkg::EV_START: begin
            seq_mode = pumpseq_pkg::MODE_WATERING;
            seq_relay = 1'b1;
            seq_entry_ms = r.now_ms;
         end
         pumpseq_pkg::EV_FORCED_ON: begin
            seq_mode = pumpseq_pkg::MODE_MANUAL;
            seq_relay = 1'b1;
            seq_entry_ms = r.now_ms;
         end
         // back to idle, but the cooldown entry time is kept
         pumpseq_pkg::EV_COOL_DONE: seq_mode = pumpseq_pkg::MODE_IDLE;
         default: begin
            seq_mode = pumpseq_pkg::MODE_COOLDOWN;
            seq_relay = 1'b0;
            seq_entry_ms = r.now_ms;
         end
      endcase

      s.pump_on = seq_relay;
      s.mode = seq_mode;
      s.event_res = ev;
      s.since_change = r.now_ms - seq_entry_ms;
      return s;
   endfunction

   function automatic pumpseq_pkg::req_type mk_req(
         input pumpseq_pkg::kind_type k,
         input logic [pumpseq_pkg::TimeWidth-1:0] now,
         input logic [pumpseq_pkg::PctWidth-1:0] soil, input logic ok,
         input logic [pumpseq_pkg::TimeWidth-1:0] dur);
      pumpseq_pkg::req_type r;
      r.kind = k;
      r.now_ms = now;
      r.soil_pct = soil;
      r.soil_ok = ok;
      r.manual_duration = dur;
      return r;
   endfunction

   function automatic pumpseq_pkg::rsp_type mk_rsp(
         input logic pump, input pumpseq_pkg::mode_type m,
         input pumpseq_pkg::event_type ev,
         input logic [pumpseq_pkg::TimeWidth-1:0] since);
      pumpseq_pkg::rsp_type s;
      s.pump_on = pump;
      s.mode = m;
      s.event_res = ev;
      s.since_change = since;
      return s;
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------
   // Offer one request, optionally after a random idle burst, and hold it until
   // the transfer. Called at a rising edge; returns at the edge of the transfer.
   task automatic send_request(input pumpseq_pkg::req_type item, input bit typed,
                               input pumpseq_pkg::rsp_type typed_status);
      pumpseq_pkg::rsp_type predicted;
      int                   gap;
      if (!quiet && $urandom_range(0, 99) < req_gap_pct) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 17);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      // transfer at this edge: advance the shadow even when the row carries its own answer
      predicted = status_after(item);
      expected_status.push_back(typed ? typed_status : predicted);
      event_seen[predicted.event_res]++;
      sent_count++;
   endtask

   // Drop valid and hold until every outstanding status has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_status.size() != 0);
   endtask

   task automatic write_setting(input logic [pumpseq_pkg::CsrIndexWidth-1:0] idx,
                                input logic [pumpseq_pkg::TimeWidth-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         pumpseq_pkg::REG_DRY_THRESHOLD: lim_dry = value[pumpseq_pkg::PctWidth-1:0];
         pumpseq_pkg::REG_WET_THRESHOLD: lim_wet = value[pumpseq_pkg::PctWidth-1:0];
         pumpseq_pkg::REG_MIN_ON_TIME:   lim_min_on = value;
         pumpseq_pkg::REG_MAX_ON_TIME:   lim_max_on = value;
         pumpseq_pkg::REG_COOLDOWN_TIME: lim_cool = value;
         default: ;
      endcase
   endtask

   // Reprogram all five registers with the pipeline empty.
   task automatic load_settings(input logic [pumpseq_pkg::TimeWidth-1:0] dry,
                                input logic [pumpseq_pkg::TimeWidth-1:0] wet,
                                input logic [pumpseq_pkg::TimeWidth-1:0] min_on,
                                input logic [pumpseq_pkg::TimeWidth-1:0] max_on,
                                input logic [pumpseq_pkg::TimeWidth-1:0] cool);
      drain_results();
      // two-stage pipeline; leave it idle to settle before the writes
      repeat (4) @(posedge clock);
      write_setting(pumpseq_pkg::REG_DRY_THRESHOLD, dry);
      write_setting(pumpseq_pkg::REG_WET_THRESHOLD, wet);
      write_setting(pumpseq_pkg::REG_MIN_ON_TIME, min_on);
      write_setting(pumpseq_pkg::REG_MAX_ON_TIME, max_on);
      write_setting(pumpseq_pkg::REG_COOLDOWN_TIME, cool);
      csr_valid <= 1'b0;
      settings_count++;
      if (!quiet) begin
         req_gap_pct = $urandom_range(0, 30);
         rsp_stall_pct = $urandom_range(0, 30);
      end
   endtask

   // Random requests, mostly sensor updates, with the clock steered onto the
   // timing boundaries of whatever state the sequencer is in.
   task automatic run_phase(input int count, input bit hold_off, input bit mid_pause);
      pumpseq_pkg::req_type item;
      int                   pick;
      for (int i = 0; i < count; i++) begin
         if (hold_off && i == 16) hold_off_req = 1'b1;
         if (mid_pause && i == count / 2) drain_results();

         item = '0;
         pick = $urandom_range(0, 99);
         if (pick < 82) item.kind = pumpseq_pkg::KIND_UPDATE;
         else if (pick < 90) item.kind = pumpseq_pkg::KIND_FORCE_ON;
         else if (pick < 96) item.kind = pumpseq_pkg::KIND_FORCE_OFF;
         else item.kind = pumpseq_pkg::KIND_UNUSED;

         // land exactly on, just short of, or just past a time limit
         case ($urandom_range(0, 9))
            0, 1, 2: wall_ms += $urandom_range(0, 50);
            3: wall_ms = seq_entry_ms + lim_min_on + $urandom_range(0, 2) - 1;
            4: wall_ms = seq_entry_ms + lim_max_on + $urandom_range(0, 2) - 1;
            5: wall_ms = seq_entry_ms + lim_cool + $urandom_range(0, 2) - 1;
            6: wall_ms = seq_entry_ms + seq_manual_ms + $urandom_range(0, 2) - 1;
            7: wall_ms = $urandom();
            default: wall_ms += $urandom_range(0, 4000);
         endcase
         item.now_ms = wall_ms;

         case ($urandom_range(0, 5))
            0: item.soil_pct = pumpseq_pkg::PctWidth'($urandom_range(0, 127));
            1: item.soil_pct = pumpseq_pkg::PctWidth'(lim_dry + $urandom_range(0, 2) - 1);
            2: item.soil_pct = pumpseq_pkg::PctWidth'(lim_wet + $urandom_range(0, 2) - 1);
            3: item.soil_pct = pumpseq_pkg::PctWidth'($urandom_range(0, lim_dry));
            4: item.soil_pct = pumpseq_pkg::PctWidth'($urandom_range(lim_wet, 127));
            default: item.soil_pct = pumpseq_pkg::PctWidth'($urandom_range(0, 100));
         endcase
         item.soil_ok = ($urandom_range(0, 9) != 0);

         case ($urandom_range(0, 4))
            0: item.manual_duration = '0;
            1: item.manual_duration = '1;
            2: item.manual_duration = $urandom();
            default: item.manual_duration = $urandom_range(0, 5000);
         endcase

         send_request(item, 1'b0, '0);
      end
   endtask

   // ------------------------------------------------------------------
   // Result side: random stall bursts plus the one long hold-off
   // ------------------------------------------------------------------
   initial begin : rsp_side
      int n;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HoldOffCycles) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_stall <= 1'b1;
            n = $urandom_range(1, 17);
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare each status transfer against the oldest expectation.
   always @(posedge clock) begin
      pumpseq_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_status.size() == 0) begin
            $error("status transfer with nothing outstanding: %h", rsp_data);
            fail_count++;
         end else begin
            want = expected_status.pop_front();
            checked_count++;
            if (rsp_data.pump_on !== want.pump_on) begin
               $error("pump_on: expected %0d, got %0d", want.pump_on, rsp_data.pump_on);
               fail_count++;
            end
            if (rsp_data.mode !== want.mode) begin
               $error("mode: expected %0d, got %0d", want.mode, rsp_data.mode);
               fail_count++;
            end
            if (rsp_data.event_res !== want.event_res) begin
               $error("event_res: expected %0d, got %0d", want.event_res, rsp_data.event_res);
               fail_count++;
            end
            if (rsp_data.since_change !== want.since_change) begin
               $error("since_change: expected %0d, got %0d",
                      want.since_change, rsp_data.since_change);
               fail_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Directed table
   // ------------------------------------------------------------------
   typedef struct {
      pumpseq_pkg::req_type item;
      bit                   typed;
      pumpseq_pkg::rsp_type want;
   } plan_row_type;

   plan_row_type directed_plan[$];

   function automatic void add_row(input pumpseq_pkg::req_type item, input bit typed,
                                   input pumpseq_pkg::rsp_type want);
      plan_row_type row;
      row.item = item;
      row.typed = typed;
      row.want = want;
      directed_plan.push_back(row);
   endfunction

   initial begin
      // Out of reset with default settings; the unused kind leaves everything alone
      add_row(mk_req(pumpseq_pkg::KIND_UNUSED, '1, 7'd127, 1'b1, '1), 1'b1,
              mk_rsp(1'b0, pumpseq_pkg::MODE_IDLE, pumpseq_pkg::EV_NONE, 32'hFFFF_FFFF));
      add_row(mk_req(pumpseq_pkg::KIND_UPDATE, 32'd100, 7'd50, 1'b1, '0), 1'b1,
              mk_rsp(1'b0, pumpseq_pkg::MODE_IDLE, pumpseq_pkg::EV_NONE, 32'd100));
      // dry but invalid: no start
      add_row(mk_req(pumpseq_pkg::KIND_UPDATE, 32'd200, 7'd10, 1'b0, '0), 1'b1,
              mk_rsp(1'b0, pumpseq_pkg::MODE_IDLE, pumpseq_pkg::EV_NONE, 32'd200));
      add_row(mk_req(pumpseq_pkg::KIND_UPDATE, 32'd300, 7'd0, 1'b1, '0), 1'b1,
              mk_rsp(1'b1, pumpseq_pkg::MODE_WATERING, pumpseq_pkg::EV_START, 32'd0));
      // wet before min on-time, then exactly at it
      add_row(mk_req(pumpseq_pkg::KIND_UPDATE, 32'd1300, 7'd100, 1'b1, '0), 1'b0, '0);
      add_row(mk_req(pumpseq_pkg::KIND_UPDATE, 32'd5300, 7'd100, 1'b1, '0), 1'b0, '0);
      // cooldown one short, then exactly done; entry time is kept
      add_row(mk_req(pumpseq_pkg::KIND_UPDATE, 32'd65299, 7'd0, 1'b1, '0), 1'b0, '0);
      add_row(mk_req(pumpseq_pkg::KIND_UPDATE, 32'd65300, 7'd0, 1'b1, '0), 1'b0, '0);
      add_row(mk_req(pumpseq_pkg::KIND_UPDATE, 32'd65400, 7'd29, 1'b1, '0), 1'b0, '0);
      // max on-time with a wet sample: safety wins
      add_row(mk_req(pumpseq_pkg::KIND_UPDATE, 32'd95400, 7'd127, 1'b1, '0), 1'b0, '0);
      // zero-length manual run ends at the next update, invalid sample or not
      add_row(mk_req(pumpseq_pkg::KIND_FORCE_ON, 32'd100000, 7'd0, 1'b0, '0), 1'b1,
              mk_rsp(1'b1, pumpseq_pkg::MODE_MANUAL, pumpseq_pkg::EV_FORCED_ON, 32'd0));
      add_row(mk_req(pumpseq_pkg::KIND_UPDATE, 32'd100000, 7'd0, 1'b0, '0), 1'b1,
              mk_rsp(1'b0, pumpseq_pkg::MODE_COOLDOWN, pumpseq_pkg::EV_MANUAL_END, 32'd0));
      // manual run across the time wrap
      add_row(mk_req(pumpseq_pkg::KIND_FORCE_ON, 32'hFFFF_FF00, 7'd0, 1'b1, 32'h200),
              1'b0, '0);
      add_row(mk_req(pumpseq_pkg::KIND_UPDATE, 32'h0000_00FF, 7'd0, 1'b1, '0), 1'b0, '0);
      add_row(mk_req(pumpseq_pkg::KIND_UPDATE, 32'h0000_0100, 7'd0, 1'b1, '0), 1'b0, '0);
      add_row(mk_req(pumpseq_pkg::KIND_FORCE_OFF, 32'h0000_0100, 7'd0, 1'b1, '0), 1'b0, '0);
      add_row(mk_req(pumpseq_pkg::KIND_UPDATE, 32'd60256, 7'd0, 1'b1, '0), 1'b0, '0);
      add_row(mk_req(pumpseq_pkg::KIND_UPDATE, 32'd60257, 7'd0, 1'b1, '0), 1'b0, '0);
      // sensor goes invalid while watering
      add_row(mk_req(pumpseq_pkg::KIND_UPDATE, 32'd60267, 7'd0, 1'b0, '0), 1'b0, '0);
      add_row(mk_req(pumpseq_pkg::KIND_FORCE_ON, 32'd60300, 7'd64, 1'b1, '1), 1'b0, '0);
      add_row(mk_req(pumpseq_pkg::KIND_UPDATE, 32'd0, 7'd0, 1'b1, '0), 1'b0, '0);
      add_row(mk_req(pumpseq_pkg::KIND_FORCE_OFF, 32'd1000, 7'd0, 1'b1, '0), 1'b0, '0);
      add_row(mk_req(pumpseq_pkg::KIND_UNUSED, 32'd2000, 7'd0, 1'b0, '0), 1'b0, '0);
      add_row(mk_req(pumpseq_pkg::KIND_UPDATE, 32'd61000, 7'd50, 1'b1, '0), 1'b0, '0);
      add_row(mk_req(pumpseq_pkg::KIND_UPDATE, 32'd61001, 7'd5, 1'b1, '0), 1'b0, '0);
      // force on in the middle of automatic watering
      add_row(mk_req(pumpseq_pkg::KIND_FORCE_ON, 32'd61002, 7'd5, 1'b1, 32'd7), 1'b0, '0);
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         send_request(directed_plan[i].item, directed_plan[i].typed, directed_plan[i].want);
      end

      wall_ms = 32'd70000;
      run_phase(PhaseItems, 1'b0, 1'b0);

      // wet threshold and every time limit at zero, dry threshold at 100: watering and cooldown end on the first update
      load_settings(32'd100, 32'd0, 32'd0, 32'd0, 32'd0);
      run_phase(PhaseItems, 1'b1, 1'b0);

      // no automatic start; long watering limits
      load_settings(32'd0, 32'd100, '1, '1, 32'd0);
      run_phase(PhaseItems, 1'b0, 1'b1);

      // all ones: thresholds keep only their low seven bits
      load_settings('1, '1, '1, '1, '1);
      run_phase(PhaseItems, 1'b0, 1'b0);

      repeat (3) begin
         load_settings($urandom_range(0, 100), $urandom_range(0, 100),
                       $urandom_range(0, 3000), $urandom_range(0, 12000),
                       $urandom_range(0, 8000));
         run_phase(PhaseItems, 1'b0, 1'b0);
      end

      // closing stretch at full rate on both sides
      quiet = 1'b1;
      load_settings($urandom_range(0, 100), $urandom_range(0, 100),
                    $urandom_range(0, 3000), $urandom_range(0, 12000),
                    $urandom_range(0, 8000));
      run_phase(PhaseItems, 1'b0, 1'b0);

      drain_results();
      repeat (8) @(posedge clock);

      $display("covered %0d requests under %0d register settings, %0d status words compared",
               sent_count, settings_count, checked_count);
      $display("transitions: start %0d, wet %0d, safety %0d, abort %0d, manual end %0d, cooled %0d",
               event_seen[pumpseq_pkg::EV_START], event_seen[pumpseq_pkg::EV_WET_STOP],
               event_seen[pumpseq_pkg::EV_SAFETY], event_seen[pumpseq_pkg::EV_ABORT],
               event_seen[pumpseq_pkg::EV_MANUAL_END], event_seen[pumpseq_pkg::EV_COOL_DONE]);
      if (fail_count == 0) begin
         $display("tb_irrigation_pump_sequencer: done, clean");
      end else begin
         $display("tb_irrigation_pump_sequencer: done, errors");
      end
      $finish;
   end

   // Watchdog: several times the slowest legal run
   initial begin
      #2_000_000;
      $display("timeout with %0d status words outstanding", expected_status.size());
      $display("tb_irrigation_pump_sequencer: done, errors");
      $finish;
   end

endmodule
